[design/ps2_mouse_packet_cursor_core_defines.svh]
// assertion macros for the ps2 mouse packet cursor block
// each macro expects clk and arst_n in the scope where it is used
`ifndef PS2_MOUSE_PACKET_CURSOR_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_CORE_DEFINES_SVH

// same-cycle implication
`define PS2MC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PS2MC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ps2mc_pkg.sv]
package ps2mc_pkg;

	localparam int SIZE_BITS = 13;
	localparam int OUT_BITS  = 12;
	localparam int BTN_BITS  = 3;

	// configuration register indexes
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	// header byte layout
	localparam int HDR_SYNC_BIT = 3;
	localparam int HDR_X_SIGN   = 4;
	localparam int HDR_Y_SIGN   = 5;

	localparam logic [SIZE_BITS-1:0] WIDTH_RST  = 13'd800;
	localparam logic [SIZE_BITS-1:0] HEIGHT_RST = 13'd600;
	localparam int POS_X_RST = 400;
	localparam int POS_Y_RST = 300;

	typedef struct packed {
		logic                fire;
		logic                await_y;
		logic [BTN_BITS-1:0] buttons;
		logic signed [8:0]   dx;
		logic signed [8:0]   dy;
	} ps2mc_pkt_t;

endpackage

[design/ps2mc_byte_if.sv]
interface ps2mc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       from_aux;

	modport source (output valid, output data_byte, output from_aux, input ready);
	modport sink (input valid, input data_byte, input from_aux, output ready);
endinterface

[design/ps2mc_cursor_if.sv]
interface ps2mc_cursor_if;
	logic                               valid;
	logic                               ready;
	logic [ps2mc_pkg::OUT_BITS-1:0]     cursor_x;
	logic [ps2mc_pkg::OUT_BITS-1:0]     cursor_y;
	logic [ps2mc_pkg::BTN_BITS-1:0]     button_bits;

	modport source (output valid, output cursor_x, output cursor_y, output button_bits,
		input ready);
	modport sink (input valid, input cursor_x, input cursor_y, input button_bits,
		output ready);
endinterface

[design/ps2_mouse_packet_cursor_core.sv]
// ps2 mouse packet cursor
// byte_in carries one byte from the controller data port per transaction,
// with from_aux marking mouse bytes; other bytes are dropped without effect.
// bytes are grouped into three-byte packets; a header needs bit 3 set, so
// the block resyncs on stray bytes. the third byte of a packet updates the
// cursor (x plus delta, y minus delta, clamped to the screen) and produces
// one transaction on cursor_out with position and button bits.
// the result is registered, valid the cycle after the third byte is taken.
// throughput: one byte per cycle unless stalled; the cursor add and clamp is
// one pass of logic into the position registers, also the result register.
// stall: while a result waits, header and x bytes are still taken; a byte in
// the third-byte phase waits until the result is taken (same cycle is fine).
// reset: cursor at 400,300, buttons clear, screen 800x600, header wait.
// cfg_wr_en writes cfg_wdata into register cfg_index (0 width, 1 height)
// and the user must use it only while the block is idle; not enforced.
`include "ps2_mouse_packet_cursor_core_defines.svh"

module ps2_mouse_packet_cursor_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ps2mc_byte_if.sink                         byte_in,
	ps2mc_cursor_if.source                     cursor_out,
	input  logic                               cfg_wr_en,
	input  logic                               cfg_index,
	input  logic [ps2mc_pkg::SIZE_BITS-1:0]    cfg_wdata
);

	// screen size registers
	logic [ps2mc_pkg::SIZE_BITS-1:0] width_q;
	logic [ps2mc_pkg::SIZE_BITS-1:0] height_q;
	// result valid and held buttons
	logic                            out_v_q;
	logic [ps2mc_pkg::BTN_BITS-1:0]  buttons_q;

	logic                  take;
	ps2mc_pkg::ps2mc_pkt_t pkt;
	logic signed [9:0]     dx_w;
	logic signed [9:0]     dy_neg_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ps2mc_pkg::WIDTH_RST;
			height_q <= ps2mc_pkg::HEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ps2mc_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
				ps2mc_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// any byte offered while the third byte is awaited waits for the result slot
	assign byte_in.ready = !(pkt.await_y && out_v_q && !cursor_out.ready);
	assign take          = byte_in.valid && byte_in.ready;

	ps2mc_packet u_packet (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (byte_in.data_byte),
		.from_aux  (byte_in.from_aux),
		.pkt       (pkt)
	);

	// 9-bit deltas widened so the y negation of -256 fits
	assign dx_w     = 10'(pkt.dx);
	assign dy_neg_w = -10'(pkt.dy);

	ps2mc_axis #(
		.COORD_BITS (COORD_BITS),
		.RESET_POS  (ps2mc_pkg::POS_X_RST)
	) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (pkt.fire),
		.delta  (dx_w),
		.size   (width_q),
		.coord  (cursor_out.cursor_x)
	);

	ps2mc_axis #(
		.COORD_BITS (COORD_BITS),
		.RESET_POS  (ps2mc_pkg::POS_Y_RST)
	) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (pkt.fire),
		.delta  (dy_neg_w),
		.size   (height_q),
		.coord  (cursor_out.cursor_y)
	);

	// result slot: set by a finished packet, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			buttons_q <= '0;
		end else begin
			if (pkt.fire) begin
				out_v_q   <= 1'b1;
				buttons_q <= pkt.buttons;
			end else if (cursor_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign cursor_out.valid       = out_v_q;
	assign cursor_out.button_bits = buttons_q;

	// a taken third byte always yields a result next cycle
	`PS2MC_ASSERT_NEXT(a_fire_gives_result, pkt.fire, cursor_out.valid,
		"completed packet produced no result")
	// a new result only appears after a completed packet
	`PS2MC_ASSERT_IMPL(a_result_from_fire, cursor_out.valid && !$past(cursor_out.valid),
		$past(pkt.fire), "result appeared without a completed packet")
	// non-mouse bytes leave the packet phase alone
	`PS2MC_ASSERT_NEXT(a_non_aux_ignored, take && !byte_in.from_aux, $stable(pkt.await_y),
		"non-mouse byte changed packet phase")

endmodule

[design/ps2mc_packet.sv]
module ps2mc_packet (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            data_byte,
	input  logic                  from_aux,
	output ps2mc_pkg::ps2mc_pkt_t pkt
);

	localparam logic [1:0] PH_HEAD = 2'd0;
	localparam logic [1:0] PH_X    = 2'd1;
	localparam logic [1:0] PH_Y    = 2'd2;

	logic [1:0] phase_q;
	logic [5:0] header_q;
	logic [7:0] xbyte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD;
			header_q <= '0;
			xbyte_q  <= '0;
		end else if (take && from_aux) begin
			unique case (phase_q)
				PH_X: begin
					xbyte_q <= data_byte;
					phase_q <= PH_Y;
				end
				PH_Y: begin
					phase_q <= PH_HEAD;
				end
				default: begin
					// unused code behaves as header wait
					if (data_byte[ps2mc_pkg::HDR_SYNC_BIT]) begin
						header_q <= data_byte[5:0];
						phase_q  <= PH_X;
					end else begin
						phase_q <= PH_HEAD;
					end
				end
			endcase
		end
	end

	always_comb begin
		pkt.await_y = (phase_q == PH_Y);
		pkt.fire    = take && from_aux && pkt.await_y;
		pkt.buttons = header_q[ps2mc_pkg::BTN_BITS-1:0];
		pkt.dx      = $signed({header_q[ps2mc_pkg::HDR_X_SIGN], xbyte_q});
		pkt.dy      = $signed({header_q[ps2mc_pkg::HDR_Y_SIGN], data_byte});
	end

endmodule

[design/ps2mc_axis.sv]
module ps2mc_axis #(
	parameter int COORD_BITS = 12,
	parameter int RESET_POS  = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic signed [9:0]                 delta,
	input  logic [ps2mc_pkg::SIZE_BITS-1:0]   size,
	output logic [ps2mc_pkg::OUT_BITS-1:0]    coord
);

	localparam int CW = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
	localparam logic [COORD_BITS-1:0] POS_RST = COORD_BITS'(RESET_POS);

	logic [COORD_BITS-1:0] pos_q;
	logic [CW-1:0]         size_w;
	logic [CW-1:0]         full_w;
	logic [CW-1:0]         lim_w;
	logic [CW-1:0]         pos_w;
	logic signed [CW-1:0]  sum_w;
	logic signed [CW-1:0]  next_w;

	assign size_w = CW'(size);
	assign full_w = CW'(1) << COORD_BITS;
	assign pos_w  = CW'(pos_q);
	assign sum_w  = $signed(pos_w) + $signed(CW'(delta));

	// zero size pins to 0, oversize pins to the coordinate range
	always_comb begin
		priority if (size_w == '0) begin
			lim_w = '0;
		end else if (size_w > full_w) begin
			lim_w = full_w - CW'(1);
		end else begin
			lim_w = size_w - CW'(1);
		end
	end

	always_comb begin
		priority if (sum_w < 0) begin
			next_w = '0;
		end else if ($unsigned(sum_w) > lim_w) begin
			next_w = $signed(lim_w);
		end else begin
			next_w = sum_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_RST;
		end else if (step) begin
			pos_q <= next_w[COORD_BITS-1:0];
		end
	end

	assign coord = pos_w[ps2mc_pkg::OUT_BITS-1:0];

endmodule

[sim/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one expected cursor report
	typedef struct {
		logic [ps2mc_pkg::OUT_BITS-1:0] x;
		logic [ps2mc_pkg::OUT_BITS-1:0] y;
		logic [ps2mc_pkg::BTN_BITS-1:0] btn;
	} cursor_t;

	// where the packet assembler stands between bytes
	typedef enum logic [1:0] {
		WAIT_HEADER,
		WAIT_X,
		WAIT_Y
	} pkt_phase_t;

	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_index;
	logic [ps2mc_pkg::SIZE_BITS-1:0] cfg_wdata;

	ps2mc_byte_if   byte_ch();
	ps2mc_cursor_if cursor_ch();

	ps2_mouse_packet_cursor_core #(
		.COORD_BITS(12)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_ch),
		.cursor_out(cursor_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// cursor tracker: mirrors the block's packet and position state
	pkt_phase_t                      phase_trk = WAIT_HEADER;
	logic [5:0]                      header_trk = '0;
	logic [7:0]                      x_byte_trk = '0;
	logic [ps2mc_pkg::OUT_BITS-1:0]  pos_x_trk = ps2mc_pkg::OUT_BITS'(ps2mc_pkg::POS_X_RST);
	logic [ps2mc_pkg::OUT_BITS-1:0]  pos_y_trk = ps2mc_pkg::OUT_BITS'(ps2mc_pkg::POS_Y_RST);
	logic [ps2mc_pkg::SIZE_BITS-1:0] width_trk = ps2mc_pkg::WIDTH_RST;
	logic [ps2mc_pkg::SIZE_BITS-1:0] height_trk = ps2mc_pkg::HEIGHT_RST;

	cursor_t cursor_expected[$];

	// knobs shared by the driver and the receiver
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic hold_kick = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	// run statistics
	int errors = 0;
	int aux_sent = 0;
	int ignored_sent = 0;
	int cursor_checked = 0;
	int edge_hits = 0;
	int config_writes = 0;

	// highest coordinate a screen size allows; 0 acts as 1, sizes cap at 4096
	function automatic int screen_limit(input logic [ps2mc_pkg::SIZE_BITS-1:0] size);
		int s;
		s = int'(size);
		if (s == 0)
			s = 1;
		if (s > (1 << ps2mc_pkg::OUT_BITS))
			s = 1 << ps2mc_pkg::OUT_BITS;
		return s - 1;
	endfunction

	function automatic int clamp_to_screen(input int v, input int lim);
		if (v < 0)
			v = 0;
		if (v > lim)
			v = lim;
		return v;
	endfunction

	// advance the tracker by one accepted byte, queueing a report on the third
	function automatic void track_byte(input logic [7:0] b, input logic aux);
		int dx;
		int dy;
		int lim_x;
		int lim_y;
		int nx;
		int ny;
		cursor_t c;
		if (!aux)
			return;
		case (phase_trk)
			WAIT_X: begin
				x_byte_trk = b;
				phase_trk = WAIT_Y;
			end
			WAIT_Y: begin
				// 9-bit deltas: sign from the header, low eight bits from the data byte
				dx = int'($signed({header_trk[ps2mc_pkg::HDR_X_SIGN], x_byte_trk}));
				dy = int'($signed({header_trk[ps2mc_pkg::HDR_Y_SIGN], b}));
				lim_x = screen_limit(width_trk);
				lim_y = screen_limit(height_trk);
				nx = clamp_to_screen(int'(pos_x_trk) + dx, lim_x);
				ny = clamp_to_screen(int'(pos_y_trk) - dy, lim_y);
				if (nx == 0 || nx == lim_x || ny == 0 || ny == lim_y)
					edge_hits++;
				pos_x_trk = ps2mc_pkg::OUT_BITS'(nx);
				pos_y_trk = ps2mc_pkg::OUT_BITS'(ny);
				c.x = pos_x_trk;
				c.y = pos_y_trk;
				c.btn = header_trk[ps2mc_pkg::BTN_BITS-1:0];
				cursor_expected.push_back(c);
				phase_trk = WAIT_HEADER;
			end
			default: begin
				// a header needs the sync bit, anything else is skipped
				if (b[ps2mc_pkg::HDR_SYNC_BIT]) begin
					header_trk = b[5:0];
					phase_trk = WAIT_X;
				end else begin
					phase_trk = WAIT_HEADER;
				end
			end
		endcase
	endfunction

	// receiver: random stalls, plus a long hold-off when kicked by a test
	always @(posedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen = hold_kick;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			cursor_ch.ready <= 1'b0;
		end else begin
			cursor_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// checker: every cursor transaction against the oldest expectation
	always @(posedge clk) begin
		cursor_t want;
		if (arst_n && cursor_ch.valid && cursor_ch.ready) begin
			if (cursor_expected.size() == 0) begin
				$error("unexpected cursor transaction x=%0d y=%0d buttons=%0d",
					cursor_ch.cursor_x, cursor_ch.cursor_y, cursor_ch.button_bits);
				errors++;
			end else begin
				want = cursor_expected.pop_front();
				cursor_checked++;
				if (cursor_ch.cursor_x !== want.x) begin
					$error("cursor_x expected %0d actual %0d", want.x, cursor_ch.cursor_x);
					errors++;
				end
				if (cursor_ch.cursor_y !== want.y) begin
					$error("cursor_y expected %0d actual %0d", want.y, cursor_ch.cursor_y);
					errors++;
				end
				if (cursor_ch.button_bits !== want.btn) begin
					$error("button_bits expected %0d actual %0d", want.btn,
						cursor_ch.button_bits);
					errors++;
				end
			end
		end
	end

	// one byte transaction; valid stays high when the next byte follows at once
	task automatic send_byte(input logic [7:0] b, input logic aux);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.from_aux <= aux;
		do @(posedge clk); while (!byte_ch.ready);
		track_byte(b, aux);
		if (aux)
			aux_sent++;
		else
			ignored_sent++;
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] mx,
		input logic [7:0] my);
		send_byte(hdr, 1'b1);
		send_byte(mx, 1'b1);
		send_byte(my, 1'b1);
	endtask

	// wait until every expected report has come back, bounded
	task automatic drain_cursor(input int max_cycles);
		int n;
		n = 0;
		while (cursor_expected.size() != 0 && n < max_cycles) begin
			@(posedge clk);
			n++;
		end
	endtask

	// screen size change, only with the block idle
	task automatic write_screen(input logic [ps2mc_pkg::SIZE_BITS-1:0] w,
		input logic [ps2mc_pkg::SIZE_BITS-1:0] h);
		byte_ch.valid <= 1'b0;
		drain_cursor(100000);
		// the result is registered after the third byte is taken; spare cycles follow
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= ps2mc_pkg::REG_SCREEN_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= ps2mc_pkg::REG_SCREEN_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		width_trk = w;
		height_trk = h;
		config_writes += 2;
	endtask

	// reset position and sizes, field extremes, ignored and dropped bytes
	task automatic test_reset_packets();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_byte(8'h08, 1'b0);          // non-mouse byte that looks like a header
		send_byte(8'h00, 1'b1);          // bad first byte
		send_byte(8'hF7, 1'b1);          // bad first byte with every other bit set
		send_packet(8'h08, 8'h00, 8'h00); // no motion from the reset position
		send_packet(8'hFF, 8'h00, 8'h00); // both deltas -256, overflow bits ignored
		send_packet(8'h0F, 8'hFF, 8'hFF); // both deltas +255, all buttons
		// non-mouse bytes interleaved inside a packet
		send_byte(8'h09, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_packet(8'h3A, 8'h01, 8'hFF);
		send_packet(8'hCC, 8'h55, 8'hAA);
	endtask

	// screen size extremes: size one, size zero, oversize, full range
	task automatic test_screen_limits();
		write_screen(13'd1, 13'd1);
		send_packet(8'h0F, 8'h40, 8'h40);
		write_screen(13'd0, 13'd8191);
		send_packet(8'h28, 8'h7F, 8'h00);
		write_screen(13'd8191, 13'd0);
		send_packet(8'h18, 8'h00, 8'h00);
		write_screen(13'd4096, 13'd4096);
		send_packet(8'h08, 8'hFF, 8'h00);
	endtask

	// mostly well-formed packets, some big moves in a slowly changing
	// direction so the clamps get hit, plus stray and non-mouse bytes
	task automatic run_random_traffic(input int n_aux);
		int sent;
		int pick;
		logic [1:0] drift;
		logic [7:0] hdr;
		logic [7:0] mx;
		logic [7:0] my;
		sent = 0;
		drift = 2'($urandom);
		while (sent < n_aux) begin
			pick = $urandom_range(99);
			if ($urandom_range(39) == 0)
				drift = 2'($urandom);
			if (pick < 8) begin
				send_byte(8'($urandom), 1'b0);
			end else if (pick < 16) begin
				// stray mouse byte: breaks or shifts the packet in progress
				send_byte(8'($urandom), 1'b1);
				sent++;
			end else begin
				hdr = 8'($urandom);
				hdr[ps2mc_pkg::HDR_SYNC_BIT] = 1'b1;
				mx = 8'($urandom);
				my = 8'($urandom);
				if ($urandom_range(9) < 4) begin
					hdr[ps2mc_pkg::HDR_X_SIGN] = drift[0];
					hdr[ps2mc_pkg::HDR_Y_SIGN] = drift[1];
					mx = drift[0] ? 8'($urandom_range(55)) : 8'($urandom_range(200, 255));
					my = drift[1] ? 8'($urandom_range(55)) : 8'($urandom_range(200, 255));
				end
				send_packet(hdr, mx, my);
				sent += 3;
			end
		end
	endtask

	// eight runs: four idling phases, each with two screen settings
	task automatic test_random_traffic();
		logic [ps2mc_pkg::SIZE_BITS-1:0] w;
		logic [ps2mc_pkg::SIZE_BITS-1:0] h;
		for (int i = 0; i < 8; i++) begin
			case (i)
				0: begin w = ps2mc_pkg::WIDTH_RST; h = ps2mc_pkg::HEIGHT_RST; end
				1: begin w = 13'd4096; h = 13'd4096; end
				2: begin w = 13'd1; h = 13'd4096; end
				3: begin w = 13'd4096; h = 13'd1; end
				4: begin w = 13'd0; h = 13'd8191; end
				5: begin w = 13'd8191; h = 13'd0; end
				6: begin
					w = 13'($urandom_range(1, 4096));
					h = 13'($urandom_range(1, 4096));
				end
				default: begin
					w = 13'($urandom_range(2, 64));
					h = 13'($urandom_range(2, 64));
				end
			endcase
			write_screen(w, h);
			case (i / 2)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 64; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 64; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			run_random_traffic(165);
		end
	endtask

	// receiver holds off for a long stretch while packets keep coming,
	// so a third byte has to wait behind the pending report
	task automatic test_backpressure();
		write_screen(ps2mc_pkg::WIDTH_RST, ps2mc_pkg::HEIGHT_RST);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_kick <= ~hold_kick;
		for (int i = 0; i < 15; i++)
			send_packet(8'($urandom) | 8'h08, 8'($urandom), 8'($urandom));
	endtask

	// safety net against a hung handshake
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.from_aux <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= ps2mc_pkg::REG_SCREEN_WIDTH;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_packets();
		test_screen_limits();
		test_random_traffic();
		test_backpressure();

		// stimulus done: let the last reports come out
		byte_ch.valid <= 1'b0;
		drain_cursor(5000);
		repeat (10) @(posedge clk);
		if (cursor_expected.size() != 0) begin
			$error("%0d cursor transactions never arrived", cursor_expected.size());
			errors++;
		end

		$display("tb: %0d mouse bytes and %0d non-mouse bytes sent, %0d size writes",
			aux_sent, ignored_sent, config_writes);
		$display("tb: %0d cursor reports checked, %0d of them on a screen edge",
			cursor_checked, edge_hits);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
